// ===== src/fts_pkg.sv =====
// fenwick tree prefix sum unit: shared types, widths and codes
// no dependencies; imported by the interfaces, controller, datapath and top level
package fts_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 10;
  localparam int AMOUNT_W = 16;
  localparam int SUM_W    = 32;
  localparam int SIZE_W   = 11;

  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_PREFIX = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY_A,
    ST_QRY_B,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic add_wr;
    logic q_issue;
    logic load_b;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic pos_in_range;
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== src/fts_if.sv =====
// fenwick tree prefix sum unit: valid/ready channel interfaces for items and results
// depends on fts_pkg for the field widths
interface fts_in_if
  import fts_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [INDEX_W-1:0]         index_a;
  logic [INDEX_W-1:0]         index_b;
  logic signed [AMOUNT_W-1:0] add_amount;

  modport source (output valid, command, index_a, index_b, add_amount, input ready);
  modport sink   (input valid, command, index_a, index_b, add_amount, output ready);
endinterface

interface fts_out_if
  import fts_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_result;
  logic                    range_flag;

  modport source (output valid, sum_result, range_flag, input ready);
  modport sink   (input valid, sum_result, range_flag, output ready);
endinterface

// ===== src/fts_ctrl.sv =====
// fenwick tree prefix sum unit: sequencing state machine
// depends on fts_pkg for the state, command and status types
module fts_ctrl
  import fts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_command_i,
  input  logic       is_range_i,
  input  ctrl_sts_t  sts_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  cmd_e   in_cmd;

  assign in_cmd = cmd_e'(in_command_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_ADD:   state_d = ST_ADD_RD;
            default:   state_d = ST_QRY_A;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_DONE;
      end
      ST_ADD_RD: begin
        if (sts_i.pos_zero || !sts_i.pos_in_range) state_d = ST_DONE;
        else state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        state_d = ST_ADD_RD;
      end
      ST_QRY_A: begin
        if (sts_i.pos_zero) state_d = is_range_i ? ST_QRY_B : ST_DRAIN;
      end
      ST_QRY_B: begin
        if (sts_i.pos_zero) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clr_wr     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.add_wr     = (state_q == ST_ADD_WR);
    cmd_o.q_issue    = ((state_q == ST_QRY_A) || (state_q == ST_QRY_B)) && !sts_i.pos_zero;
    cmd_o.load_b     = (state_q == ST_QRY_A) && sts_i.pos_zero && is_range_i;
    cmd_o.out_load   = (state_q == ST_DONE) && sts_i.out_free;
  end

endmodule

// ===== src/fts_datapath.sv =====
// fenwick tree prefix sum unit: cell store, walk position, accumulator and result register
// depends on fts_pkg for widths and the controller command and status types
module fts_datapath
  import fts_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [SIZE_W-1:0]          cfg_wdata_i,
  input  logic [CMD_W-1:0]           in_command_i,
  input  logic [INDEX_W-1:0]         in_index_a_i,
  input  logic [INDEX_W-1:0]         in_index_b_i,
  input  logic signed [AMOUNT_W-1:0] in_add_amount_i,
  input  ctrl_cmd_t                  cmd_i,
  output ctrl_sts_t                  sts_o,
  output logic                       is_range_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SUM_W-1:0]    out_sum_o,
  output logic                       out_flag_o
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  logic [SUM_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0]   size_q;
  logic [CW-1:0]       size_ext, eff_size;
  logic [CW-1:0]       a_ext, b_ext, a_clamp, b_clamp;
  logic                a_over, b_over, in_query, in_range;
  logic [CW-1:0]       pos_q, pos_d, low_bit;
  logic [CW-1:0]       b_q;
  logic [AW-1:0]       clr_cnt_q;
  logic [SUM_W-1:0]    rdata_q, acc_q, amount_q, amount_ext;
  logic                rd_valid_q, rd_neg_q, neg_q;
  logic                is_range_q, flag_q;
  logic                out_valid_q, out_flag_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [SUM_W-1:0]    mem_wdata;

  // size register, taken as written and clamped into one to depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign size_ext = CW'(size_q);
  always_comb begin
    if (size_ext == '0) eff_size = CW'(1);
    else if (size_ext > DEPTH_C) eff_size = DEPTH_C;
    else eff_size = size_ext;
  end

  // query end clamping on item transfer
  assign a_ext    = CW'(in_index_a_i);
  assign b_ext    = CW'(in_index_b_i);
  assign a_over   = (a_ext >= eff_size);
  assign b_over   = (b_ext >= eff_size);
  assign a_clamp  = a_over ? (eff_size - CW'(1)) : a_ext;
  assign b_clamp  = b_over ? (eff_size - CW'(1)) : b_ext;
  assign in_query = (cmd_e'(in_command_i) == CMD_PREFIX) ||
                    (cmd_e'(in_command_i) == CMD_RANGE);
  assign in_range = (cmd_e'(in_command_i) == CMD_RANGE);

  // walk position: climb for add, descend for query
  assign low_bit = pos_q & (~pos_q + CW'(1));
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.load) pos_d = in_query ? a_clamp : a_ext;
    else if (cmd_i.add_wr) pos_d = pos_q + low_bit;
    else if (cmd_i.q_issue) pos_d = pos_q - low_bit;
    else if (cmd_i.load_b) pos_d = b_q;
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load) begin
      b_q      <= b_clamp;
      amount_q <= amount_ext;
    end
  end

  assign amount_ext = {{(SUM_W - AMOUNT_W){in_add_amount_i[AMOUNT_W-1]}}, in_add_amount_i};

  // item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_range_q <= 1'b0;
      flag_q     <= 1'b0;
      neg_q      <= 1'b0;
    end else if (cmd_i.load) begin
      is_range_q <= in_range;
      flag_q     <= (in_query && a_over) || (in_range && b_over);
      neg_q      <= 1'b0;
    end else if (cmd_i.load_b) begin
      neg_q      <= 1'b1;
    end
  end

  // clearing sweep counter, back at zero after the last cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= (clr_cnt_q == LAST_C) ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // single port cell store with registered read
  assign mem_we    = cmd_i.clr_wr || cmd_i.add_wr;
  assign mem_addr  = cmd_i.clr_wr ? clr_cnt_q : pos_q[AW-1:0];
  assign mem_wdata = cmd_i.clr_wr ? '0 : rdata_q + amount_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // read tracking for the query accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_neg_q   <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.q_issue;
      rd_neg_q   <= neg_q;
    end
  end

  // accumulator, wraps modulo two to the 32
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (rd_valid_q) begin
      acc_q <= rd_neg_q ? (acc_q - rdata_q) : (acc_q + rdata_q);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sum_q  <= acc_q;
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_flag_o  = out_flag_q;
  assign is_range_o  = is_range_q;

  // status for the controller
  assign sts_o.pos_zero     = (pos_q == '0);
  assign sts_o.pos_in_range = (pos_q < eff_size);
  assign sts_o.clr_last     = (clr_cnt_q == LAST_C);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

// ===== src/fenwick_tree_prefix_sum_unit.sv =====
// fenwick tree prefix sum unit: top level joining controller and datapath to the channels
// depends on fts_pkg, fts_if, fts_ctrl and fts_datapath
//
// Binary indexed tree over DEPTH cells of 32 bits held in one single-port memory with
// registered read. Items are taken one at a time; every item gives exactly one result.
// After reset the block sweeps zeros through all DEPTH cells, one a cycle, and takes no
// item until the sweep is done; a clear command runs the same sweep. An add walks up
// from its position by the lowest set bit, reading then writing each cell visited
// through the one port. A prefix query reads one cell a cycle while descending. A range
// query runs two such descents back to back. The result is held in an output register,
// so the next item is taken while a result still waits for its transfer. The size
// register (cfg_we_i, cfg_wdata_i) resets to 1024; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
module fenwick_tree_prefix_sum_unit
  import fts_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  fts_in_if.sink            in_i,
  fts_out_if.source         out_o
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;
  logic      is_range;
  logic      out_valid;
  logic      out_flag;
  logic signed [SUM_W-1:0] out_sum;

  // sequencing
  fts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .is_range_i   (is_range),
    .sts_i        (ctrl_sts),
    .in_ready_o   (in_i.ready),
    .cmd_o        (ctrl_cmd)
  );

  // store and arithmetic
  fts_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_command_i    (in_i.command),
    .in_index_a_i    (in_i.index_a),
    .in_index_b_i    (in_i.index_b),
    .in_add_amount_i (in_i.add_amount),
    .cmd_i           (ctrl_cmd),
    .sts_o           (ctrl_sts),
    .is_range_o      (is_range),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_valid),
    .out_sum_o       (out_sum),
    .out_flag_o      (out_flag)
  );

  // result channel
  assign out_o.valid      = out_valid;
  assign out_o.sum_result = out_sum;
  assign out_o.range_flag = out_flag;

endmodule
